FILE: hdl/pds_pkg.sv
// pds_pkg: widths, constants and the divider request/response types
// shared by the aliquot-sum block. No dependencies.
package pds_pkg;

  localparam int unsigned NUMBER_W        = 31;    // input number width
  localparam int unsigned SUM_W           = 34;    // result width
  localparam int unsigned PRIME_W         = 16;    // prime table entry width
  localparam int unsigned CAND_W          = PRIME_W + 1;  // fill candidate, can pass the limit
  localparam int unsigned DIV_CNT_W       = $clog2(NUMBER_W + 1);
  localparam int unsigned PRIME_COUNT_DEF = 4830;
  localparam int unsigned PRIME_LIMIT_DEF = 46656;
  localparam int unsigned FIRST_PRIME     = 2;

  typedef struct packed {
    logic                start;
    logic                short_op;  // dividend fits in PRIME_W bits
    logic [NUMBER_W-1:0] dividend;
    logic [PRIME_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [NUMBER_W-1:0] quot;
    logic [PRIME_W-1:0]  rem;
  } div_rsp_t;

endpackage

FILE: hdl/pds_divider.sv
// pds_divider: restoring divider, one quotient bit per cycle.
// 31-bit dividend by 16-bit divisor; short ops run 16 steps. Uses pds_pkg.
module pds_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pds_pkg::div_req_t req_i,
  output pds_pkg::div_rsp_t rsp_o
);
  import pds_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUMBER_W-1:0]  quot_q;
  logic [PRIME_W-1:0]   rem_q;
  logic [PRIME_W-1:0]   dvs_q;

  logic [PRIME_W:0]     trial;
  logic [PRIME_W:0]     diff;
  logic                 fits;
  logic [PRIME_W-1:0]   rem_d;
  logic [NUMBER_W-1:0]  quot_d;

  assign trial  = {rem_q, quot_q[NUMBER_W-1]};
  assign diff   = trial - {1'b0, dvs_q};
  assign fits   = trial >= {1'b0, dvs_q};
  assign rem_d  = fits ? diff[PRIME_W-1:0] : trial[PRIME_W-1:0];
  assign quot_d = {quot_q[NUMBER_W-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.short_op ? DIV_CNT_W'(PRIME_W) : DIV_CNT_W'(NUMBER_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      dvs_q  <= req_i.divisor;
      quot_q <= req_i.short_op
                ? {req_i.dividend[PRIME_W-1:0], (NUMBER_W-PRIME_W)'(0)}
                : req_i.dividend;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: hdl/proper_divisor_sum.sv
// proper_divisor_sum: aliquot sum by trial division over a prime table in RAM.
// After reset the table is filled by trial division (in_stall_o stays
// high), then items are accepted. Each prime tried and each repeated
// factor takes one full-width run of the bit-serial divider.
// One item in flight; the output register lets the next item enter early.
module proper_divisor_sum #(
  parameter int unsigned PRIME_COUNT = pds_pkg::PRIME_COUNT_DEF,
  parameter int unsigned PRIME_LIMIT = pds_pkg::PRIME_LIMIT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pds_pkg::NUMBER_W-1:0] number_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pds_pkg::SUM_W-1:0]    divisor_sum_o
);
  import pds_pkg::*;

  localparam int unsigned IDX_W = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(PRIME_COUNT + 1);

  // Fill states (F_*) build the table once after reset; S_* run items.
  typedef enum logic [13:0] {
    F_INIT = 14'b00000000000001,
    F_CAND = 14'b00000000000010,
    F_RD   = 14'b00000000000100,
    F_CHK  = 14'b00000000001000,
    F_DIV  = 14'b00000000010000,
    S_IDLE = 14'b00000000100000,
    S_RD   = 14'b00000001000000,
    S_CHK  = 14'b00000010000000,
    S_DIV  = 14'b00000100000000,
    S_ACC  = 14'b00001000000000,
    S_LAST = 14'b00010000000000,
    S_MLO  = 14'b00100000000000,
    S_MHI  = 14'b01000000000000,
    S_FIN  = 14'b10000000000000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    held_q, held_d;   // primes stored so far
  logic [CNT_W-1:0]    idx_q, idx_d;     // table index being tried
  logic [CAND_W-1:0]   cand_q, cand_d;   // fill candidate
  logic [NUMBER_W-1:0] num_q, num_d;
  logic [NUMBER_W-1:0] rest_q, rest_d;   // remaining cofactor
  logic [SUM_W-1:0]    sigma_q, sigma_d; // divisor sum of the part factored
  logic [SUM_W-1:0]    acc_q, acc_d;     // running geometric sum times sigma
  logic [SUM_W-1:0]    prod_q, prod_d;   // sigma * p^k, or partial product
  logic                out_valid_q;
  logic [SUM_W-1:0]    out_data_q;

  // Prime table: one write port (fill), one registered read port.
  logic [PRIME_W-1:0]  prime_mem [PRIME_COUNT];
  logic [PRIME_W-1:0]  rd_data_q;
  logic                mem_we;
  logic                mem_re;
  logic [PRIME_W-1:0]  wr_data;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [2*PRIME_W-1:0]       sq;
  logic                       sq_gt_rest;
  logic                       sq_gt_cand;
  logic                       p_small;
  logic [SUM_W-1:0]           mul_a;
  logic [PRIME_W-1:0]         mul_b;
  logic [SUM_W+PRIME_W-1:0]   mul_full;
  logic [SUM_W-1:0]           mul_lo;
  logic                       out_free;

  assign wr_data = (state_q == F_INIT) ? PRIME_W'(FIRST_PRIME) : cand_q[PRIME_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prime_mem[held_q[IDX_W-1:0]] <= wr_data;
    end
    if (mem_re) begin
      rd_data_q <= prime_mem[idx_q[IDX_W-1:0]];
    end
  end

  // Stop test: p*p against the cofactor (items) or the candidate (fill).
  assign sq         = (2*PRIME_W)'(rd_data_q) * (2*PRIME_W)'(rd_data_q);
  assign sq_gt_rest = sq > (2*PRIME_W)'(rest_q);
  assign sq_gt_cand = sq > (2*PRIME_W)'(cand_q);
  assign p_small    = rd_data_q < PRIME_W'(FIRST_PRIME);

  // One shared 34x16 multiplier: sigma*p^k steps, and the final
  // sigma*(rest+1) taken as two 16-bit halves of rest.
  always_comb begin
    mul_a = (state_q == S_DIV) ? prod_q : sigma_q;
    if (state_q == S_DIV) begin
      mul_b = rd_data_q;
    end else if (state_q == S_LAST) begin
      mul_b = rest_q[PRIME_W-1:0];
    end else begin
      mul_b = {1'b0, rest_q[NUMBER_W-1:PRIME_W]};
    end
  end
  assign mul_full = (SUM_W+PRIME_W)'(mul_a) * (SUM_W+PRIME_W)'(mul_b);
  assign mul_lo   = mul_full[SUM_W-1:0];

  assign out_free = !out_valid_q || !out_stall_i;

  pds_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d  = state_q;
    held_d   = held_q;
    idx_d    = idx_q;
    cand_d   = cand_q;
    num_d    = num_q;
    rest_d   = rest_q;
    sigma_d  = sigma_q;
    acc_d    = acc_q;
    prod_d   = prod_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    div_req.start    = 1'b0;
    div_req.short_op = (state_q == F_CHK);
    div_req.dividend = (state_q == F_CHK) ? NUMBER_W'(cand_q[PRIME_W-1:0]) : rest_q;
    div_req.divisor  = rd_data_q;

    unique case (state_q)
      F_INIT: begin
        mem_we  = 1'b1;
        held_d  = CNT_W'(1);
        cand_d  = CAND_W'(FIRST_PRIME + 1);
        state_d = F_CAND;
      end
      F_CAND: begin
        if (cand_q >= CAND_W'(PRIME_LIMIT) || held_q == CNT_W'(PRIME_COUNT)) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = CNT_W'(1);  // odd candidates only, skip 2
          state_d = F_RD;
        end
      end
      F_RD: begin
        if (idx_q == held_q) begin
          mem_we  = 1'b1;
          held_d  = held_q + CNT_W'(1);
          cand_d  = cand_q + CAND_W'(2);
          state_d = F_CAND;
        end else begin
          mem_re  = 1'b1;
          state_d = F_CHK;
        end
      end
      F_CHK: begin
        if (sq_gt_cand) begin
          mem_we  = 1'b1;
          held_d  = held_q + CNT_W'(1);
          cand_d  = cand_q + CAND_W'(2);
          state_d = F_CAND;
        end else begin
          div_req.start = 1'b1;
          state_d       = F_DIV;
        end
      end
      F_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            cand_d  = cand_q + CAND_W'(2);
            state_d = F_CAND;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = F_RD;
          end
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          num_d  = number_i;
          rest_d = number_i;
          idx_d  = '0;
          if (number_i == '0) begin
            sigma_d = '0;
            state_d = S_FIN;
          end else begin
            sigma_d = SUM_W'(1);
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (idx_q == held_q) begin
          state_d = S_LAST;
        end else begin
          mem_re  = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (p_small || sq_gt_rest) begin
          state_d = S_LAST;
        end else begin
          acc_d         = sigma_q;
          prod_d        = sigma_q;
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            rest_d  = div_rsp.quot;
            prod_d  = mul_lo;
            state_d = S_ACC;
          end else begin
            sigma_d = acc_q;
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_RD;
          end
        end
      end
      S_ACC: begin
        acc_d         = acc_q + prod_q;
        div_req.start = 1'b1;
        state_d       = S_DIV;
      end
      S_LAST: begin
        // leftover cofactor of at least 2 is a prime: sigma *= rest + 1
        if (rest_q < NUMBER_W'(2)) begin
          state_d = S_FIN;
        end else begin
          acc_d   = sigma_q;
          prod_d  = mul_lo;
          state_d = S_MLO;
        end
      end
      S_MLO: begin
        acc_d   = acc_q + prod_q;
        prod_d  = mul_lo;
        state_d = S_MHI;
      end
      S_MHI: begin
        sigma_d = acc_q + (prod_q << PRIME_W);
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_INIT;
      held_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      idx_q   <= idx_d;
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    num_q   <= num_d;
    rest_q  <= rest_d;
    sigma_q <= sigma_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    if (state_q == S_FIN && out_free) begin
      out_data_q <= sigma_q - SUM_W'(num_q);
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign divisor_sum_o = out_data_q;

  // table reads only hit entries already written
  a_read_below_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (idx_q < held_q))
    else $error("prime table read beyond filled entries");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (held_q < CNT_W'(PRIME_COUNT)))
    else $error("prime table write past its depth");

  a_table_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(held_q))
    else $error("prime count changed after fill");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV || state_q == F_DIV))
    else $error("divider finished with nobody waiting");

  a_result_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (out_valid_o && state_q == S_IDLE))
    else $error("finished item not loaded into output register");

endmodule
